### hdl/smoothed_rms_level_meter_defines.svh
// assertion macros for the level meter
`ifndef SMOOTHED_RMS_LEVEL_METER_DEFINES_SVH
`define SMOOTHED_RMS_LEVEL_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srlm check failed");
`define SRLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srlm check failed");
`else
`define SRLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SRLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/srlm_pkg.sv
`timescale 1ns / 1ps
package srlm_pkg;

    localparam int MAX_FRAMES  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_W     = 16;
    localparam int CFG_W       = 16;

    // two samples per pair, count saturates at 2 * MAX_FRAMES
    localparam int CNT_W  = $clog2(2 * MAX_FRAMES + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + $clog2(2 * MAX_FRAMES);
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int STEP_W = $clog2(SUM_W + 1);

    // rescale root from SAMPLE_BITS to LEVEL_W fraction bits
    localparam int SH_L      = (SAMPLE_BITS < LEVEL_W) ? (LEVEL_W - SAMPLE_BITS) : 0;
    localparam int SH_R      = (SAMPLE_BITS > LEVEL_W) ? (SAMPLE_BITS - LEVEL_W) : 0;
    localparam int RMS_EXT_W = ROOT_W + SH_L + 1;
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;

    localparam int PROD_W     = 2 * LEVEL_W + 2;
    localparam int ROUND_HALF = 1 << (LEVEL_W - 1);

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(2 * MAX_FRAMES);
    localparam logic [CNT_W-1:0] CNT_INC   = CNT_W'(2);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'd1;
    localparam logic [CFG_W-1:0]     NEW_WEIGHT_RST = 16'd4588;
    localparam logic [CFG_W-1:0]     FULL_SCALE_RST = 16'd11141;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_acc_entry;

endpackage

### hdl/srlm_front.sv
`timescale 1ns / 1ps
module srlm_front import srlm_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                          i_last_frame,
    output logic                          o_full,
    output logic                          o_q_push,
    output t_acc_entry                    o_q_data,
    input  logic                          i_q_full
);

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_SQUARE = 4'b0010,
        F_ADD    = 4'b0100,
        F_PUSH   = 4'b1000
    } t_front_state;

    t_front_state                  r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_left, r_right;
    logic                          r_last;
    logic [SQ_W-1:0]               r_sq_l, r_sq_r;
    logic [SUM_W-1:0]              r_sum, n_sum;
    logic [CNT_W-1:0]              r_cnt, n_cnt;

    logic [SAMPLE_BITS-1:0]   w_abs_l, w_abs_r;
    logic [2*SAMPLE_BITS-1:0] w_prod_l, w_prod_r;

    // magnitude of the most negative code still fits unsigned
    assign w_abs_l  = r_left[SAMPLE_BITS-1]  ? unsigned'(~r_left + 1'b1)  : unsigned'(r_left);
    assign w_abs_r  = r_right[SAMPLE_BITS-1] ? unsigned'(~r_right + 1'b1) : unsigned'(r_right);
    assign w_prod_l = w_abs_l * w_abs_l;
    assign w_prod_r = w_abs_r * w_abs_r;

    assign o_full   = (r_state != F_IDLE);
    assign o_q_data = '{sum: r_sum, cnt: r_cnt};

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        o_q_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) n_state = F_SQUARE;
            end
            F_SQUARE: begin
                n_state = F_ADD;
            end
            F_ADD: begin
                // pairs past the frame limit are dropped
                if (r_cnt < CNT_LIMIT) begin
                    n_sum = r_sum + SUM_W'(r_sq_l) + SUM_W'(r_sq_r);
                    n_cnt = r_cnt + CNT_INC;
                end
                n_state = r_last ? F_PUSH : F_IDLE;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_sum    = '0;
                    n_cnt    = '0;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
            r_last  <= i_last_frame;
        end
        r_sq_l <= w_prod_l[SQ_W-1:0];
        r_sq_r <= w_prod_r[SQ_W-1:0];
    end

endmodule

### hdl/srlm_queue.sv
`timescale 1ns / 1ps
module srlm_queue import srlm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_acc_entry i_data,
    output logic       o_full,
    input  logic       i_pop,
    output t_acc_entry o_data,
    output logic       o_empty
);

    t_acc_entry         r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_wr, w_rd;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

### hdl/srlm_back.sv
`timescale 1ns / 1ps
module srlm_back import srlm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_acc_entry         i_q_data,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [CFG_W-1:0]   i_new_weight,
    input  logic [CFG_W-1:0]   i_full_scale,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [LEVEL_W-1:0] o_smoothed_level,
    output logic [LEVEL_W-1:0] o_scaled_level
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_DIV   = 7'b0000010,
        B_SQRT  = 7'b0000100,
        B_MUL   = 7'b0001000,
        B_BLEND = 7'b0010000,
        B_SCALE = 7'b0100000,
        B_OUT   = 7'b1000000
    } t_back_state;

    t_back_state               r_state;
    logic [STEP_W-1:0]         r_step;
    logic [SUM_W-1:0]          r_div_q, n_div_q;
    logic [CNT_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_divisor;
    logic [SQ_W-1:0]           r_x, n_x;
    logic [SQ_W:0]             r_root, n_root;
    logic [SQ_W-1:0]           r_bit;
    logic [LEVEL_W-1:0]        r_rms;
    logic signed [PROD_W-1:0]  r_prod;
    logic [LEVEL_W-1:0]        r_level;
    logic [LEVEL_W-1:0]        r_srem, n_srem;
    logic [LEVEL_W-1:0]        r_quo;
    logic                      r_out_valid;
    logic [LEVEL_W-1:0]        r_out_level, r_out_scaled;

    logic [CNT_W:0]             w_rem_sh, w_rem_sub;
    logic                       w_div_bit;
    logic [SQ_W:0]              w_trial;
    logic [RMS_EXT_W-1:0]       w_rms_ext;
    logic [LEVEL_W-1:0]         w_rms;
    logic signed [LEVEL_W:0]    w_diff, w_weight;
    logic signed [PROD_W-1:0]   w_round, w_delta;
    logic signed [LEVEL_W+1:0]  w_lvl_sum;
    logic [LEVEL_W-1:0]         w_lvl;
    logic [LEVEL_W:0]           w_srem_sh;
    logic                       w_scale_bit;
    logic                       w_out_load;

    // restoring divide of sum by count, one quotient bit a cycle
    assign w_rem_sh  = {r_rem, r_div_q[SUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_divisor};
    assign w_div_bit = (w_rem_sh >= {1'b0, r_divisor});
    assign n_rem     = w_div_bit ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
    assign n_div_q   = {r_div_q[SUM_W-2:0], w_div_bit};

    // digit-by-digit root, one result bit a cycle
    assign w_trial = r_root + {1'b0, r_bit};
    always_comb begin
        if ({1'b0, r_x} >= w_trial) begin
            n_x    = r_x - w_trial[SQ_W-1:0];
            n_root = (r_root >> 1) + {1'b0, r_bit};
        end else begin
            n_x    = r_x;
            n_root = r_root >> 1;
        end
    end

    assign w_rms_ext = (RMS_EXT_W'(n_root[ROOT_W-1:0]) << SH_L) >> SH_R;
    assign w_rms     = (w_rms_ext > RMS_EXT_W'(LEVEL_MAX)) ? '1 : w_rms_ext[LEVEL_W-1:0];

    // old*(1-w) + new*w folded into old + (new-old)*w
    assign w_diff    = $signed({1'b0, r_rms}) - $signed({1'b0, r_level});
    assign w_weight  = $signed({1'b0, i_new_weight});
    assign w_round   = r_prod + $signed(PROD_W'(ROUND_HALF));
    assign w_delta   = w_round >>> LEVEL_W;
    assign w_lvl_sum = $signed({2'b00, r_level}) + $signed(w_delta[LEVEL_W+1:0]);
    always_comb begin
        if (w_lvl_sum[LEVEL_W+1]) begin
            w_lvl = '0;
        end else if (w_lvl_sum[LEVEL_W]) begin
            w_lvl = '1;
        end else begin
            w_lvl = w_lvl_sum[LEVEL_W-1:0];
        end
    end

    // fraction bits of level / full scale, level already below full scale
    assign w_srem_sh   = {r_srem, 1'b0};
    assign w_scale_bit = (w_srem_sh >= {1'b0, i_full_scale});
    assign n_srem      = w_scale_bit ? (w_srem_sh[LEVEL_W-1:0] - i_full_scale)
                                     : w_srem_sh[LEVEL_W-1:0];

    assign o_q_pop          = (r_state == B_IDLE) && !i_q_empty;
    assign w_out_load       = (r_state == B_OUT) && (!r_out_valid || i_pop);
    assign o_empty          = !r_out_valid;
    assign o_smoothed_level = r_out_level;
    assign o_scaled_level   = r_out_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_div_q   <= i_q_data.sum;
                        r_divisor <= i_q_data.cnt;
                        r_rem     <= '0;
                        r_step    <= '0;
                        r_state   <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_div_q <= n_div_q;
                    r_rem   <= n_rem;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        // an empty count reads as zero mean
                        r_x     <= (r_divisor == '0) ? '0 : n_div_q[SQ_W-1:0];
                        r_root  <= '0;
                        r_bit   <= SQ_W'(1) << (2 * (ROOT_W - 1));
                        r_step  <= '0;
                        r_state <= B_SQRT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                B_SQRT: begin
                    r_x    <= n_x;
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(ROOT_W - 1)) begin
                        r_rms   <= w_rms;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= w_diff * w_weight;
                    r_state <= B_BLEND;
                end
                B_BLEND: begin
                    r_level <= w_lvl;
                    r_srem  <= w_lvl;
                    r_step  <= '0;
                    // zero full scale falls here as well
                    if (w_lvl >= i_full_scale) begin
                        r_quo   <= '1;
                        r_state <= B_OUT;
                    end else begin
                        r_quo   <= '0;
                        r_state <= B_SCALE;
                    end
                end
                B_SCALE: begin
                    r_srem <= n_srem;
                    r_quo  <= {r_quo[LEVEL_W-2:0], w_scale_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(LEVEL_W - 1)) r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_out_load) begin
                        r_out_level  <= r_level;
                        r_out_scaled <= r_quo;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

### hdl/smoothed_rms_level_meter.sv
`timescale 1ns / 1ps
// smoothed rms level meter
// input side: one stereo pair per transaction on i_left_sample / i_right_sample,
// taken when push is high and full is low; i_last_frame closes a buffer.
// result side: one result per closed buffer (smoothed and scaled level), shown
// while empty is low and taken when pop is high.
// the front takes one pair at a time (latch, square, add); a closing pair holds
// full through a push step to hand its sum over a two-entry queue.
// the back works one buffer at a time: sum / count divide, root, multiply and
// blend, and a level / full-scale divide (skipped when it saturates).
// configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index (0 new
// weight, 1 full scale); the user writes only while the block is idle, not enforced.
// reset (synchronous, i_rst_n low) clears the sum, count, smoothed level, queue
// and result register and restores the register defaults.
// when pop stays low the result holds, the back waits, the queue fills and full
// stays high; nothing is dropped.
`include "smoothed_rms_level_meter_defines.svh"
module smoothed_rms_level_meter import srlm_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                          i_last_frame,
    output logic                          empty,
    input  logic                          pop,
    output logic [LEVEL_W-1:0]            o_smoothed_level,
    output logic [LEVEL_W-1:0]            o_scaled_level,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    logic [CFG_W-1:0] r_new_weight, r_full_scale;
    t_acc_entry       w_fq_data, w_qb_data;
    logic             w_q_push, w_q_full, w_q_pop, w_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_weight <= NEW_WEIGHT_RST;
            r_full_scale <= FULL_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NEW_WEIGHT: r_new_weight <= i_cfg_data;
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    srlm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_last_frame   (i_last_frame),
        .o_full         (full),
        .o_q_push       (w_q_push),
        .o_q_data       (w_fq_data),
        .i_q_full       (w_q_full)
    );

    srlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_fq_data),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_qb_data),
        .o_empty (w_q_empty)
    );

    srlm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_data         (w_qb_data),
        .i_q_empty        (w_q_empty),
        .o_q_pop          (w_q_pop),
        .i_new_weight     (r_new_weight),
        .i_full_scale     (r_full_scale),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_smoothed_level (o_smoothed_level),
        .o_scaled_level   (o_scaled_level)
    );

    // the front is busy right after it takes a transaction
    `SRLM_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, push && !full, full)
    // buffer sums never handed to a full queue
    `SRLM_ASSERT_SAME(a_q_no_overrun, i_clk, i_rst_n, w_q_push, !w_q_full)
    // the back only takes sums that are there
    `SRLM_ASSERT_SAME(a_q_no_underrun, i_clk, i_rst_n, w_q_pop, !w_q_empty)

endmodule

### test/tb_smoothed_rms_level_meter.sv
`timescale 1ns / 1ps
module tb_smoothed_rms_level_meter;
    import srlm_pkg::*;

    localparam int SETTLE_CYCLES  = 100;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef struct packed {
        logic [LEVEL_W-1:0] smoothed;
        logic [LEVEL_W-1:0] scaled;
    } t_level_pair;

    class t_level_scoreboard;
        logic [63:0]        square_total;
        int unsigned        samples_summed;
        logic [LEVEL_W-1:0] level_now;
        logic [CFG_W-1:0]   weight;
        logic [CFG_W-1:0]   full_scale;
        t_level_pair        levels_due[$];
        int unsigned        errors;
        int unsigned        pairs_taken;
        int unsigned        buffers_checked;
        int unsigned        saturated_buffers;

        function new();
            square_total      = '0;
            samples_summed    = 0;
            level_now         = '0;
            weight            = NEW_WEIGHT_RST;
            full_scale        = FULL_SCALE_RST;
            errors            = 0;
            pairs_taken       = 0;
            buffers_checked   = 0;
            saturated_buffers = 0;
        endfunction

        function void set_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] fs);
            weight     = w;
            full_scale = fs;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // bit-by-bit floor square root, result fits in 32 bits
        function logic [63:0] floor_root(logic [63:0] x);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x) root = trial;
            end
            return root;
        endfunction

        function void note_pair(logic signed [SAMPLE_BITS-1:0] l,
                                logic signed [SAMPLE_BITS-1:0] r, logic last);
            logic signed [2*SAMPLE_BITS-1:0] l_sq;
            logic signed [2*SAMPLE_BITS-1:0] r_sq;
            logic [63:0] rms;
            logic [63:0] blend;
            logic [63:0] quot;
            t_level_pair due;
            pairs_taken++;
            if (samples_summed < 2 * MAX_FRAMES) begin
                l_sq = l * l;
                r_sq = r * r;
                square_total += 64'(unsigned'(l_sq)) + 64'(unsigned'(r_sq));
                samples_summed += 2;
            end
            if (!last) return;
            if (samples_summed >= 2 * MAX_FRAMES) saturated_buffers++;
            rms = (samples_summed == 0) ? 64'd0 : floor_root(square_total / samples_summed);
            rms = (rms >> SH_R) << SH_L;
            if (rms > LEVEL_MAX) rms = 64'(LEVEL_MAX);
            blend = (64'(level_now) * (64'd65536 - 64'(weight)) + rms * 64'(weight)
                     + 64'(ROUND_HALF)) >> LEVEL_W;
            if (blend > LEVEL_MAX) blend = 64'(LEVEL_MAX);
            level_now = blend[LEVEL_W-1:0];
            if (full_scale == '0) begin
                quot = 64'(LEVEL_MAX);
            end else begin
                quot = (blend << LEVEL_W) / 64'(full_scale);
                if (quot > LEVEL_MAX) quot = 64'(LEVEL_MAX);
            end
            due.smoothed = blend[LEVEL_W-1:0];
            due.scaled   = quot[LEVEL_W-1:0];
            levels_due.insert(levels_due.size(), due);
            square_total   = '0;
            samples_summed = 0;
        endfunction

        function void check_result(logic [LEVEL_W-1:0] smoothed, logic [LEVEL_W-1:0] scaled);
            t_level_pair due;
            if (levels_due.size() == 0) begin
                $display("%0t: unexpected level result, smoothed %0d scaled %0d",
                         $time, smoothed, scaled);
                errors++;
                return;
            end
            due = levels_due.pop_front();
            buffers_checked++;
            if (smoothed !== due.smoothed) begin
                $display("%0t: smoothed_level mismatch, expected %0d, actual %0d",
                         $time, due.smoothed, smoothed);
                errors++;
            end
            if (scaled !== due.scaled) begin
                $display("%0t: scaled_level mismatch, expected %0d, actual %0d",
                         $time, due.scaled, scaled);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] i_left_sample;
    logic signed [SAMPLE_BITS-1:0] i_right_sample;
    logic                          i_last_frame;
    logic                          empty;
    logic                          pop;
    logic [LEVEL_W-1:0]            o_smoothed_level;
    logic [LEVEL_W-1:0]            o_scaled_level;
    logic                          i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_W-1:0]              i_cfg_data;

    t_level_scoreboard sb = new();
    bit                hold_req = 1'b0;
    int                holds_done = 0;
    int                settings_used = 0;
    int                burst_left = 0;
    int                idle_cycles = 0;

    smoothed_rms_level_meter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_last_frame     (i_last_frame),
        .empty            (empty),
        .pop              (pop),
        .o_smoothed_level (o_smoothed_level),
        .o_scaled_level   (o_scaled_level),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ends the run when neither side has moved a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.pending());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: stall modes of random length, plus one long hold-off on request
    initial begin : result_sink
        int stall_mode;
        int mode_left;
        pop <= 1'b0;
        stall_mode = 0;
        mode_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_smoothed_level, o_scaled_level);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: return v;
            1: return v >>> $urandom_range(1, 14);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return '0;
                    3:       return '1;
                    default: return SAMPLE_BITS'(1);
                endcase
            end
            default: return v >>> 3;
        endcase
    endfunction

    // bursts of random length with random gaps in between
    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
        burst_left--;
        push           <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        i_last_frame   <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_pair(l, r, last);
    endtask

    // sender pauses until every result is back, then lets the front finish
    task automatic settle_block();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] fs);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_NEW_WEIGHT;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_FULL_SCALE;
        i_cfg_data  <= fs;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_regs(w, fs);
        settings_used++;
    endtask

    // mostly short buffers, now and then a longer one
    task automatic run_buffers(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send_pair(pick_sample(), pick_sample(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_left_sample  <= '0;
        i_right_sample <= '0;
        i_last_frame   <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= CFG_NEW_WEIGHT;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sample extremes with the reset weights
        send_pair(MOST_POS, MOST_POS, 1'b1);
        send_pair(MOST_NEG, MOST_NEG, 1'b1);
        send_pair('0, '0, 1'b1);
        send_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b0);
        send_pair(SAMPLE_BITS'(-1), SAMPLE_BITS'(1), 1'b1);
        send_pair(MOST_NEG, MOST_POS, 1'b0);
        send_pair(16'sh4000, -16'sh2000, 1'b0);
        send_pair(SAMPLE_BITS'(-123), SAMPLE_BITS'(4567), 1'b1);

        // weight all on the new value, widest full scale
        settle_block();
        set_config('1, '1);
        send_pair(MOST_NEG, MOST_NEG, 1'b1);
        send_pair('0, '0, 1'b1);

        // level frozen, smallest full scale saturates the scaled value
        settle_block();
        set_config('0, 16'd1);
        send_pair(MOST_POS, '0, 1'b1);
        send_pair('0, '0, 1'b1);

        // zero full scale
        settle_block();
        set_config(16'd1, '0);
        send_pair(MOST_POS, MOST_NEG, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            settle_block();
            case (phase)
                0: set_config(NEW_WEIGHT_RST, FULL_SCALE_RST);
                1: set_config('1, '1);
                2: set_config(CFG_W'($urandom), CFG_W'($urandom_range(1, 4000)));
                3: set_config(CFG_W'($urandom), '0);
                4: set_config('0, CFG_W'($urandom_range(1, 65535)));
                default: set_config(CFG_W'($urandom), CFG_W'($urandom_range(1, 65535)));
            endcase
            // long receiver hold-off so the queue fills and full holds the input
            if (phase == 2) hold_req = 1'b1;
            run_buffers(55);
            // one buffer runs past the frame limit
            if (phase == 5) begin
                for (int i = 0; i < MAX_FRAMES + 4; i++)
                    send_pair(pick_sample(), pick_sample(), i == MAX_FRAMES + 3);
            end
        end
        settle_block();

        $display("covered %0d sample pairs, %0d buffer results checked, %0d past the frame limit",
                 sb.pairs_taken, sb.buffers_checked, sb.saturated_buffers);
        $display("%0d register settings incl. zero and maximum values, %0d long result hold-offs",
                 settings_used, holds_done);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
